// ----- src/swmax_pkg.sv -----
// ----------------------------------------------------------------------------
// swmax_pkg
// shared types and constants of the sliding window maximum block
// ----------------------------------------------------------------------------
`default_nettype none

package swmax_pkg;

   // width of the window size register
   localparam int unsigned WIN_CFG_W = 7;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;      // latch the sample, apply start flag
      logic front_rd;    // read the front entry
      logic front_pop;   // drop the front entry
      logic front_keep;  // keep the front entry, latch its value
      logic back_rd;     // read the back entry
      logic back_pop;    // remove the back entry
      logic commit;      // append the sample and issue the result once the window is full
   } swmax_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic count_zero;      // queue is empty
      logic front_expired;   // front entry has left the window
      logic back_dominated;  // back entry is not greater than the sample
      logic out_full;        // result register still holds a pending transfer
   } swmax_status_type;

endpackage : swmax_pkg

`default_nettype wire

// ----- src/swmax_ram.sv -----
// ----------------------------------------------------------------------------
// swmax_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module swmax_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64
) (
   input  wire                                        clock,
   input  wire                                        write_enable,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  wire [WIDTH-1:0]                            write_data,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                           read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      rd_data_ff <= mem_ff[read_addr];
   end

   assign read_data = rd_data_ff;

endmodule : swmax_ram

`default_nettype wire

// ----- src/swmax_ctrl.sv -----
// ----------------------------------------------------------------------------
// swmax_ctrl
// sequencer for front drops, back removals and the append of one sample
// ----------------------------------------------------------------------------
`default_nettype none

module swmax_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  swmax_pkg::swmax_status_type status,
   output swmax_pkg::swmax_cmd_type    cmd
);

   import swmax_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_FRONT_RD  = 3'd1;
   localparam logic [2:0] ST_FRONT_CHK = 3'd2;
   localparam logic [2:0] ST_BACK_RD   = 3'd3;
   localparam logic [2:0] ST_BACK_CHK  = 3'd4;
   localparam logic [2:0] ST_COMMIT    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_FRONT_RD;
            end
         end
         ST_FRONT_RD: begin
            if (status.count_zero) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.front_rd = 1'b1;
               state_in     = ST_FRONT_CHK;
            end
         end
         ST_FRONT_CHK: begin
            if (status.front_expired) begin
               cmd.front_pop = 1'b1;
               state_in      = ST_FRONT_RD;
            end else begin
               cmd.front_keep = 1'b1;
               state_in       = ST_BACK_RD;
            end
         end
         ST_BACK_RD: begin
            if (status.count_zero) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.back_rd = 1'b1;
               state_in    = ST_BACK_CHK;
            end
         end
         ST_BACK_CHK: begin
            if (status.back_dominated) begin
               cmd.back_pop = 1'b1;
               state_in     = ST_BACK_RD;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!status.out_full) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : swmax_ctrl

`default_nettype wire

// ----- src/swmax_dp.sv -----
// ----------------------------------------------------------------------------
// swmax_dp
// queue pointers, window register, entry ram and result register
// ----------------------------------------------------------------------------
`default_nettype none

module swmax_dp #(
   parameter int unsigned MAX_WINDOW = 64,
   parameter int unsigned DATA_WIDTH = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  swmax_pkg::swmax_cmd_type             cmd,
   output swmax_pkg::swmax_status_type          status,
   input  wire signed [DATA_WIDTH-1:0]          req_sample,
   input  wire                                  req_start_sequence,
   input  wire                                  csr_write_enable,
   input  wire [swmax_pkg::WIN_CFG_W-1:0]       csr_write_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]         rsp_window_max
);

   import swmax_pkg::*;

   localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned CW = $clog2(MAX_WINDOW) + 1;
   localparam int unsigned EW = DATA_WIDTH + CW;
   localparam logic [CW:0] DEPTH_EXT = (CW+1)'(MAX_WINDOW);
   localparam logic [CW-1:0] MAX_K = CW'(MAX_WINDOW);

   // circular slot arithmetic, depth need not be a power of two
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[AW-1:0];
   endfunction

   logic [WIN_CFG_W-1:0]   win_ff;
   logic [AW-1:0]          head_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          pos_ff;
   logic [CW-1:0]          seen_ff;
   logic signed [DATA_WIDTH-1:0] x_ff;
   logic signed [DATA_WIDTH-1:0] front_ff;
   logic                   rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_max_ff;

   logic [CW-1:0]          k_eff;
   logic [CW-1:0]          seen_in;
   logic [AW-1:0]          head_slot;
   logic [AW-1:0]          tail_slot;
   logic [AW-1:0]          append_slot;
   logic [AW-1:0]          read_addr;
   logic [EW-1:0]          rd_entry;
   logic signed [DATA_WIDTH-1:0] rd_value;
   logic [CW-1:0]          rd_pos;
   logic [CW-1:0]          rd_age;

   // window size zero acts as one, large values clamp to the depth
   always_comb begin
      if (win_ff == '0) begin
         k_eff = CW'(1);
      end else if (32'(win_ff) > 32'(MAX_WINDOW)) begin
         k_eff = MAX_K;
      end else begin
         k_eff = CW'(win_ff);
      end
   end

   assign head_slot   = head_ff;
   assign tail_slot   = slot_of(head_ff, count_ff - CW'(1));
   assign append_slot = slot_of(head_ff, count_ff);
   assign read_addr   = cmd.back_rd ? tail_slot : head_slot;

   assign rd_value = $signed(rd_entry[EW-1:CW]);
   assign rd_pos   = rd_entry[CW-1:0];
   assign rd_age   = pos_ff - rd_pos;

   assign seen_in = (seen_ff < k_eff) ? (seen_ff + CW'(1)) : seen_ff;

   assign status.count_zero     = (count_ff == '0);
   assign status.front_expired  = (rd_age >= k_eff);
   assign status.back_dominated = (rd_value <= x_ff);
   assign status.out_full       = rsp_valid_ff && !rsp_ready;

   swmax_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_WINDOW)
   ) u_ram (
      .clock        (clock),
      .write_enable (cmd.commit),
      .write_addr   (append_slot),
      .write_data   ({x_ff, pos_ff}),
      .read_addr    (read_addr),
      .read_data    (rd_entry)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WIN_CFG_W'(1);
         head_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            win_ff   <= csr_write_data;
            head_ff  <= '0;
            count_ff <= '0;
            pos_ff   <= '0;
            seen_ff  <= '0;
         end else if (cmd.accept && req_start_sequence) begin
            head_ff  <= '0;
            count_ff <= '0;
            pos_ff   <= '0;
            seen_ff  <= '0;
         end else if (cmd.front_pop) begin
            head_ff  <= slot_of(head_ff, CW'(1));
            count_ff <= count_ff - CW'(1);
         end else if (cmd.back_pop) begin
            count_ff <= count_ff - CW'(1);
         end else if (cmd.commit) begin
            count_ff <= count_ff + CW'(1);
            pos_ff   <= pos_ff + CW'(1);
            seen_ff  <= seen_in;
         end

         if (cmd.commit && (seen_in >= k_eff)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff <= req_sample;
      end
      if (cmd.front_keep) begin
         front_ff <= rd_value;
      end
      if (cmd.commit) begin
         rsp_max_ff <= (count_ff == '0) ? x_ff : front_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

endmodule : swmax_dp

`default_nettype wire

// ----- src/sliding_window_max_monotonic_queue.sv -----
// ----------------------------------------------------------------------------
// sliding_window_max_monotonic_queue
// running maximum over the last window_size samples, kept as a monotonic queue
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid/req_ready, sample, start flag | in
//   rsp     | rsp_valid/rsp_ready, window_max         | out
//   csr     | csr_write_enable, csr_write_data        | in
//
// a sample is accepted, expired front entries are dropped, dominated back
// entries are removed and then the sample is appended; each inspected
// entry is a ram read with a registered result followed by a check; the
// next sample is taken only after the append
// reset clears the pointers and sets the window to one; the entry ram is
// not cleared, entries are read only after they are written
// the append waits while the result register holds an untaken transfer
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_monotonic_queue #(
   parameter int unsigned MAX_WINDOW = 64,
   parameter int unsigned DATA_WIDTH = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   // sample transfers in
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire signed [DATA_WIDTH-1:0]      req_sample,
   input  wire                              req_start_sequence,
   // window maximum transfers out
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic signed [DATA_WIDTH-1:0]     rsp_window_max,
   // window size register
   input  wire                              csr_write_enable,
   input  wire [swmax_pkg::WIN_CFG_W-1:0]   csr_write_data
);

   import swmax_pkg::*;

   swmax_cmd_type    cmd;
   swmax_status_type status;

   // sequencer: accept, drop expired front entries, remove dominated
   // back entries, then append and issue the front value
   swmax_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // pointers, entry ram and the result register
   swmax_dp #(
      .MAX_WINDOW (MAX_WINDOW),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sample         (req_sample),
      .req_start_sequence (req_start_sequence),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_window_max     (rsp_window_max)
   );

endmodule : sliding_window_max_monotonic_queue

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sliding window maximum block: a directed
// table and randomized sample streams under several window sizes, with each
// window max transfer checked in order against a typed-in value or a monotonic queue model
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_WINDOW   = 64;
   localparam int unsigned DATA_WIDTH   = 16;
   localparam int          RANDOM_ITEMS = 450;
   // bound on one sample: every entry inspected and popped once, plus overhead
   localparam int          DRAIN_CYCLES = 4 * MAX_WINDOW + 16;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;
   typedef enum logic [2:0] {
      MODE_SPREAD, MODE_NARROW, MODE_FALL, MODE_RISE, MODE_EXTREME
   } sample_mode_type;

   typedef struct {
      row_kind_type                  kind;
      logic [swmax_pkg::WIN_CFG_W-1:0] csr_value;
      logic signed [DATA_WIDTH-1:0]  sample;
      bit                            start;
      bit                            fixed;      // expected max typed in the row
      logic signed [DATA_WIDTH-1:0]  fixed_max;
   } stim_row_type;

   localparam int N_ROWS = 25;

   // directed part: extremes, warm-up, expiry, equal samples, start flag,
   // window of zero and oversize window
   stim_row_type directed_rows [N_ROWS] = '{
      // window of one after reset, every sample comes straight back
      '{ROW_SAMPLE, 7'd0,   16'h8000, 1'b0, 1'b1, 16'h8000},
      '{ROW_SAMPLE, 7'd0,   16'h7fff, 1'b1, 1'b1, 16'h7fff},
      '{ROW_SAMPLE, 7'd0,   16'h0000, 1'b0, 1'b1, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'hffff, 1'b0, 1'b1, 16'hffff},
      // window of three: warm-up, equal samples, front expiry
      '{ROW_CSR,    7'd3,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'd5,    1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'd5,    1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'd5,    1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   -16'sd1,  1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   -16'sd2,  1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   -16'sd3,  1'b0, 1'b0, 16'h0000},
      // restart in the middle of a running window
      '{ROW_SAMPLE, 7'd0,   16'd100,  1'b1, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h7fff, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h8000, 1'b0, 1'b0, 16'h0000},
      // window size zero acts as one
      '{ROW_CSR,    7'd0,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h1234, 1'b0, 1'b1, 16'h1234},
      '{ROW_SAMPLE, 7'd0,   16'h5555, 1'b1, 1'b1, 16'h5555},
      // oversize window saturates, still warming up
      '{ROW_CSR,    7'd127, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h2aaa, 1'b0, 1'b0, 16'h0000},
      // window of two: rising run removes from the back
      '{ROW_CSR,    7'd2,   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'd10,   1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'd20,   1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'd30,   1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'd7,    1'b0, 1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'd6,    1'b0, 1'b0, 16'h0000}
   };

   logic                                clock;
   logic                                reset              = 1'b1;
   logic                                req_valid          = 1'b0;
   logic                                req_ready;
   logic signed [DATA_WIDTH-1:0]        req_sample         = '0;
   logic                                req_start_sequence = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready          = 1'b0;
   logic signed [DATA_WIDTH-1:0]        rsp_window_max;
   logic                                csr_write_enable   = 1'b0;
   logic [swmax_pkg::WIN_CFG_W-1:0]     csr_write_data     = '0;

   // random idling on both channels, off for one long phase
   bit stall_en = 1'b1;

   // window maxima still owed by the block, oldest first
   logic signed [DATA_WIDTH-1:0] max_expect_q [$];
   int fail_count = 0;

   // model of the candidate queue
   logic [swmax_pkg::WIN_CFG_W-1:0] window_reg;
   logic signed [DATA_WIDTH-1:0]    cand_value [MAX_WINDOW];
   int unsigned                     cand_pos   [MAX_WINDOW];
   int unsigned                     cand_head;
   int unsigned                     cand_count;
   int unsigned                     next_pos;
   int unsigned                     warm_count;

   sliding_window_max_monotonic_queue #(
      .MAX_WINDOW (MAX_WINDOW),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_start_sequence (req_start_sequence),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_window_max     (rsp_window_max),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // effective window: zero acts as one, anything above the depth saturates
   function automatic int unsigned span_of(input logic [swmax_pkg::WIN_CFG_W-1:0] w);
      if (w == 0)
         return 1;
      if (w > MAX_WINDOW)
         return MAX_WINDOW;
      return 32'(w);
   endfunction

   function automatic void clear_candidates();
      cand_head  = 0;
      cand_count = 0;
      next_pos   = 0;
      warm_count = 0;
   endfunction

   // one sample through the candidate queue; returns 1 when a max is due
   function automatic bit advance_window(input logic signed [DATA_WIDTH-1:0] s,
                                         input bit st,
                                         output logic signed [DATA_WIDTH-1:0] wmax);
      int unsigned span;
      int unsigned here;
      span = span_of(window_reg);
      if (st)
         clear_candidates();
      here = next_pos;
      // front entries older than the window leave first
      while (cand_count > 0 && (here - cand_pos[cand_head]) >= span) begin
         cand_head  = (cand_head + 1) % MAX_WINDOW;
         cand_count = cand_count - 1;
      end
      // back entries not above the new sample can never be the max again
      while (cand_count > 0 &&
             cand_value[(cand_head + cand_count - 1) % MAX_WINDOW] <= s)
         cand_count = cand_count - 1;
      if (cand_count < MAX_WINDOW) begin
         cand_value[(cand_head + cand_count) % MAX_WINDOW] = s;
         cand_pos[(cand_head + cand_count) % MAX_WINDOW]   = here;
         cand_count = cand_count + 1;
      end
      next_pos = here + 1;
      if (warm_count < span)
         warm_count = warm_count + 1;
      wmax = cand_value[cand_head];
      return warm_count >= span;
   endfunction

   // register write only once the block has gone quiet
   task automatic write_window(input logic [swmax_pkg::WIN_CFG_W-1:0] w);
      req_valid <= 1'b0;
      while (max_expect_q.size() != 0)
         @(posedge clock);
      // an item in warm-up leaves no result behind, give it time to finish
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_reg = w;
      clear_candidates();
   endtask

   // one sample transfer, with random gaps before it
   task automatic send_item(input logic signed [DATA_WIDTH-1:0] s, input bit st,
                            input bit fixed, input logic signed [DATA_WIDTH-1:0] fixed_max);
      logic signed [DATA_WIDTH-1:0] wmax;
      bit                           due;
      while (stall_en && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sample         <= s;
      req_start_sequence <= st;
      do
         @(posedge clock);
      while (!req_ready);
      due = advance_window(s, st, wmax);
      if (fixed)
         max_expect_q.insert(max_expect_q.size(), fixed_max);
      else if (due)
         max_expect_q.insert(max_expect_q.size(), wmax);
   endtask

   // result side: random backpressure and in-order check of every transfer
   always @(posedge clock) begin
      logic signed [DATA_WIDTH-1:0] want;
      rsp_ready <= stall_en ? ($urandom_range(0, 99) >= 19) : 1'b1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (max_expect_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected window max transfer: got %0d", rsp_window_max);
         end else begin
            want = max_expect_q[0];
            max_expect_q.delete(0);
            if (rsp_window_max !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("window max mismatch: expected %0d, got %0d",
                           want, rsp_window_max);
            end
         end
      end
   end

   initial begin
      sample_mode_type              mode;
      int                           burst_left;
      int                           random_items;
      int                           phase;
      int                           n_items;
      int unsigned                  span;
      int unsigned                  pick;
      logic [swmax_pkg::WIN_CFG_W-1:0] w;
      logic signed [DATA_WIDTH-1:0] s;
      logic signed [DATA_WIDTH-1:0] prev;
      logic [DATA_WIDTH-1:0]        step;
      bit                           st;

      window_reg = 7'd1;
      clear_candidates();
      mode         = MODE_SPREAD;
      burst_left   = 0;
      random_items = 0;
      phase        = 0;
      prev         = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < N_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CSR)
            write_window(directed_rows[r].csr_value);
         else
            send_item(directed_rows[r].sample, directed_rows[r].start,
                      directed_rows[r].fixed, directed_rows[r].fixed_max);
      end

      // random phases: extreme window settings first, then mostly small ones
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0: w = 7'd64;
            1: w = 7'd127;
            2: w = 7'd65;
            3: w = 7'd1;
            4: w = 7'd0;
            default: w = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                     : 7'($urandom_range(1, 8));
         endcase
         // one long stretch with no idling on either side
         stall_en <= (phase != 2);
         write_window(w);
         span    = span_of(w);
         n_items = int'(span + $urandom_range(20, 50));
         for (int i = 0; i < n_items; i++) begin
            if (burst_left == 0) begin
               pick = $urandom_range(0, 5);
               // falling runs grow the queue deepest, so they come twice as often
               mode = (pick == 5) ? MODE_FALL : sample_mode_type'(pick);
               burst_left = int'($urandom_range(4, 40));
            end
            burst_left--;
            case (mode)
               MODE_SPREAD: s = 16'($urandom);
               MODE_NARROW: s = $signed({13'd0, 3'($urandom_range(0, 6))}) - 16'sd3;
               MODE_FALL: begin
                  step = 16'($urandom_range(0, 40));
                  s = prev - step;
               end
               MODE_RISE: begin
                  step = 16'($urandom_range(0, 40));
                  s = prev + step;
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0: s = 16'h8000;
                     1: s = 16'h7fff;
                     2: s = 16'h0000;
                     default: s = 16'hffff;
                  endcase
               end
            endcase
            prev = s;
            // restarts are rare enough that long windows still fill up
            st = (i == 0) ? bit'($urandom_range(0, 1))
                          : ($urandom_range(0, 4 * span + 16) == 0);
            send_item(s, st, 1'b0, '0);
            random_items++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (max_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #10_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
